/* src/ahsl_pkg.sv */
package ahsl_pkg;

    // Default fraction width of the internal H, S, L fixed-point values
    localparam int FRAC_BITS_DEF = 12;

    // Offset registers count in 1/4096 steps
    localparam int OFS_SHIFT = 12;
    localparam int OFS_SCALE = 1 << OFS_SHIFT;

    // Configuration port widths and register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;
    localparam logic [CFG_IDX_W-1:0] CFG_HUE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIT = 2'd2;

    // Hue sectors, named by the channel carrying chroma, then the one carrying X
    localparam logic [2:0] SEC_RG = 3'd0;
    localparam logic [2:0] SEC_GR = 3'd1;
    localparam logic [2:0] SEC_GB = 3'd2;
    localparam logic [2:0] SEC_BG = 3'd3;
    localparam logic [2:0] SEC_BR = 3'd4;

    // Classified pixel handed from the front end to the back end
    typedef struct packed {
        logic [7:0]  alpha;
        logic [7:0]  chroma;   // max - min
        logic [8:0]  sum;      // max + min
        logic [10:0] num;      // hue sector numerator
        logic        gray;     // zero chroma
    } t_item;

    // Adjustment settings
    typedef struct packed {
        logic [11:0]        hue_ofs;
        logic signed [13:0] sat_ofs;
        logic signed [13:0] lit_ofs;
    } t_cfg;

endpackage

/* src/ahsl_front.sv */
module ahsl_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req,
    input  logic [31:0]          i_pixel,
    output logic                 o_valid,
    output ahsl_pkg::t_item      o_item
);

    logic [7:0]  red, grn, blu, mx, mn, d;
    logic [10:0] num;
    ahsl_pkg::t_item n_item;
    ahsl_pkg::t_item r_item;
    logic            r_valid;

    assign red = i_pixel[23:16];
    assign grn = i_pixel[15:8];
    assign blu = i_pixel[7:0];

    // Find the extremes of the three channels
    always_comb begin
        mx = red;
        mn = red;
        if (grn > mx) mx = grn;
        if (blu > mx) mx = blu;
        if (grn < mn) mn = grn;
        if (blu < mn) mn = blu;
        d = mx - mn;
    end

    // Pick the hue sector numerator
    always_comb begin
        if (mx == red) begin
            num = (grn >= blu) ? 11'(grn - blu)
                               : 11'(11'(d) * 11'd6) - 11'(blu - grn);
        end else if (mx == grn) begin
            num = 11'(11'(d) * 11'd2) + 11'(blu) - 11'(red);
        end else begin
            num = 11'(11'(d) * 11'd4) + 11'(red) - 11'(grn);
        end
    end

    always_comb begin
        n_item.alpha  = i_pixel[31:24];
        n_item.chroma = d;
        n_item.sum    = 9'(mx) + 9'(mn);
        n_item.num    = num;
        n_item.gray   = (d == 8'd0);
    end

    // Register the classified request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_req;
        end
        r_item <= n_item;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* src/ahsl_queue.sv */
module ahsl_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ahsl_pkg::t_item  i_item,
    input  logic             i_pop,
    output logic             o_empty,
    output logic             o_full,
    output ahsl_pkg::t_item  o_item
);

    ahsl_pkg::t_item r_mem [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    logic            push_ok, pop_ok;

    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rp];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) r_wp <= ~r_wp;
            if (pop_ok)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push_ok) - 2'(pop_ok);
        end
    end

    // Store the request
    always_ff @(posedge i_clk) begin
        if (push_ok) r_mem[r_wp] <= i_item;
    end

endmodule

/* src/ahsl_back.sv */
module ahsl_back #(
    parameter int FRAC_BITS = ahsl_pkg::FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  ahsl_pkg::t_item  i_item,
    input  ahsl_pkg::t_cfg   i_cfg,
    output logic             o_strobe,
    output logic [31:0]      o_pixel
);

    localparam int F    = FRAC_BITS;
    localparam int Q    = F + 1;          // quotient bits
    localparam int NW   = F + 13;         // dividend width
    localparam int DW   = 12;             // divisor width
    localparam int ONE  = 1 << F;
    localparam int HW   = F + 14;         // scaled hue width
    localparam int TW   = F + 16;         // scaled signed S/L width
    localparam int PW   = 2 * F + 2;      // product width
    localparam int VW   = F + 3;          // doubled channel width
    localparam int CW   = F + 11;         // channel scaling width
    localparam int LW   = F + 8;          // halved lightness dividend width
    localparam logic [HW-1:0] WRAP  = HW'(ahsl_pkg::OFS_SCALE) << F;
    localparam logic [TW-1:0] TOP_T = TW'(ahsl_pkg::OFS_SCALE) << F;
    localparam logic [F:0]    ONE_V = (F+1)'(ONE);
    localparam logic [PW-1:0] HALF  = PW'(ONE / 2);
    // ceil(2^31 / 255): exact quotient for dividends below 2^24
    localparam logic [23:0]   RCP_255 = 24'h808081;

    // Lanes of the shared divider
    localparam int LN_HUE = 0;
    localparam int LN_SAT = 1;

    function automatic logic [F:0] adj_clamp(input logic [F:0] base,
                                             input logic signed [13:0] off);
        logic signed [TW-1:0] t;
        logic [TW-1:0]        tr;
        t = $signed(TW'(base) << ahsl_pkg::OFS_SHIFT) + (TW'(off) <<< F);
        if (t < 0) begin
            tr = '0;
        end else if (t > $signed(TOP_T)) begin
            tr = TOP_T;
        end else begin
            tr = $unsigned(t);
        end
        return (F+1)'((tr + TW'(ahsl_pkg::OFS_SCALE / 2)) >> ahsl_pkg::OFS_SHIFT);
    endfunction

    function automatic logic [7:0] to_chan(input logic [VW-1:0] v2);
        logic [CW-1:0] t;
        t = ((CW'(v2) * CW'(255)) + CW'(ONE)) >> (F + 1);
        return (t > CW'(255)) ? 8'hFF : t[7:0];
    endfunction

    // ---------------- divider inputs ----------------
    logic [8:0]    den_s;
    logic [NW-1:0] s0_rem [2];
    logic [DW-1:0] s0_den [2];
    logic [F+8:0]  lit_n;
    logic [LW-1:0] lit_m;
    logic [LW+23:0] lit_p;
    logic [F:0]    lit_q;

    always_comb begin
        den_s = (i_item.sum < 9'd255) ? i_item.sum : 9'(10'd510 - 10'(i_item.sum));
        s0_rem[LN_HUE] = (NW'(i_item.num) << (F + 1)) + NW'(12'(i_item.chroma) * 12'd6);
        s0_den[LN_HUE] = 12'(i_item.chroma) * 12'd12;
        s0_rem[LN_SAT] = (NW'(i_item.chroma) << (F + 1)) + NW'(den_s);
        s0_den[LN_SAT] = {2'b00, den_s, 1'b0};
    end

    // Lightness: rounded sum * ONE / 510 as a halved dividend over 255
    always_comb begin
        lit_n = ((F+9)'(i_item.sum) << F) + (F+9)'(255);
        lit_m = lit_n[F+8:1];
        lit_p = (LW+24)'(lit_m) * (LW+24)'(RCP_255);
        lit_q = (F+1)'(lit_p >> 31);
    end

    // ---------------- restoring divider, one quotient bit per stage ----------------
    logic [NW-1:0] r_rem [Q][2];
    logic [DW-1:0] r_den [Q][2];
    logic [Q-1:0]  r_quo [Q][2];
    logic [Q-1:0]  r_dv;
    logic [7:0]    r_da [Q];
    logic [Q-1:0]  r_dg;
    logic [F:0]    r_dl [Q];
    logic [NW-1:0] n_rem [Q][2];
    logic [DW-1:0] n_den [Q][2];
    logic [Q-1:0]  n_quo [Q][2];
    logic [Q-1:0]  n_dv;
    logic [7:0]    n_da [Q];
    logic [Q-1:0]  n_dg;
    logic [F:0]    n_dl [Q];

    always_comb begin
        logic [NW-1:0] rin;
        logic [NW-1:0] sub;
        logic [DW-1:0] dn;
        logic [Q-1:0]  qin;
        for (int g = 0; g < Q; g++) begin
            if (g == 0) begin
                n_dv[g] = i_valid;
                n_da[g] = i_item.alpha;
                n_dg[g] = i_item.gray;
                n_dl[g] = lit_q;
            end else begin
                n_dv[g] = r_dv[g-1];
                n_da[g] = r_da[g-1];
                n_dg[g] = r_dg[g-1];
                n_dl[g] = r_dl[g-1];
            end
            for (int k = 0; k < 2; k++) begin
                if (g == 0) begin
                    rin = s0_rem[k];
                    dn  = s0_den[k];
                    qin = '0;
                end else begin
                    rin = r_rem[g-1][k];
                    dn  = r_den[g-1][k];
                    qin = r_quo[g-1][k];
                end
                sub = NW'(dn) << (Q - 1 - g);
                n_den[g][k] = dn;
                if (rin >= sub) begin
                    n_rem[g][k] = rin - sub;
                    n_quo[g][k] = {qin[Q-2:0], 1'b1};
                end else begin
                    n_rem[g][k] = rin;
                    n_quo[g][k] = {qin[Q-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
        end else begin
            r_dv <= n_dv;
        end
        for (int g = 0; g < Q; g++) begin
            r_da[g] <= n_da[g];
            r_dg[g] <= n_dg[g];
            r_dl[g] <= n_dl[g];
            for (int k = 0; k < 2; k++) begin
                r_rem[g][k] <= n_rem[g][k];
                r_den[g][k] <= n_den[g][k];
                r_quo[g][k] <= n_quo[g][k];
            end
        end
    end

    // ---------------- stage A: apply offsets ----------------
    logic [Q-1:0]  hq;
    logic [F-1:0]  h0;
    logic [F:0]    s0v;
    logic [HW-1:0] hs;
    logic [F:0]    hr;
    logic [F-1:0]  n_ah;
    logic [F:0]    n_as, n_al;
    logic          r_av;
    logic [7:0]    r_aa;
    logic [F-1:0]  r_ah;
    logic [F:0]    r_as, r_al;

    always_comb begin
        hq  = r_quo[Q-1][LN_HUE];
        h0  = r_dg[Q-1] ? '0 : ((hq >= ONE_V) ? F'(hq - ONE_V) : F'(hq));
        s0v = r_dg[Q-1] ? '0 : r_quo[Q-1][LN_SAT];
        // Wrap hue modulo one turn
        hs  = (HW'(h0) << ahsl_pkg::OFS_SHIFT) + (HW'(i_cfg.hue_ofs) << F);
        if (hs >= WRAP) hs = hs - WRAP;
        hr  = (F+1)'((hs + HW'(ahsl_pkg::OFS_SCALE / 2)) >> ahsl_pkg::OFS_SHIFT);
        n_ah = (hr >= ONE_V) ? F'(hr - ONE_V) : F'(hr);
        n_as = adj_clamp(s0v, i_cfg.sat_ofs);
        n_al = adj_clamp(r_dl[Q-1], i_cfg.lit_ofs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
        end else begin
            r_av <= r_dv[Q-1];
        end
        r_aa <= r_da[Q-1];
        r_ah <= n_ah;
        r_as <= n_as;
        r_al <= n_al;
    end

    // ---------------- stage B: chroma and hue position ----------------
    logic [F+1:0]  bl2, dev;
    logic [F:0]    span;
    logic [PW-1:0] prod_c;
    logic [F+2:0]  hh;
    logic [F:0]    f;
    logic [F:0]    n_bc, n_bfd;
    logic          r_bv;
    logic [7:0]    r_ba;
    logic [F:0]    r_bc, r_bfd, r_bl;
    logic [2:0]    r_bsec;

    always_comb begin
        bl2 = {r_al, 1'b0};
        dev = (bl2 >= (F+2)'(ONE)) ? bl2 - (F+2)'(ONE) : (F+2)'(ONE) - bl2;
        if (dev > (F+2)'(ONE)) dev = (F+2)'(ONE);
        span   = (F+1)'((F+2)'(ONE) - dev);
        prod_c = PW'(span) * PW'(r_as);
        n_bc   = (F+1)'((prod_c + HALF) >> F);
        hh     = (F+3)'(r_ah) * (F+3)'(6);
        f      = hh[F:0];
        n_bfd  = (f >= ONE_V) ? f - ONE_V : ONE_V - f;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= 1'b0;
        end else begin
            r_bv <= r_av;
        end
        r_ba   <= r_aa;
        r_bc   <= n_bc;
        r_bfd  <= n_bfd;
        r_bl   <= r_al;
        r_bsec <= 3'(hh >> F);
    end

    // ---------------- stage C: secondary component and base ----------------
    logic [PW-1:0] prod_x;
    logic [F+1:0]  cl2;
    logic          r_cv;
    logic [7:0]    r_ca;
    logic [F:0]    r_cx, r_cc;
    logic [F+1:0]  r_cm;
    logic [2:0]    r_csec;

    always_comb begin
        prod_x = PW'(r_bc) * PW'(ONE_V - r_bfd);
        cl2    = {r_bl, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= 1'b0;
        end else begin
            r_cv <= r_bv;
        end
        r_ca   <= r_ba;
        r_cx   <= (F+1)'((prod_x + HALF) >> F);
        r_cc   <= r_bc;
        r_cm   <= ((F+2)'(r_bc) > cl2) ? '0 : cl2 - (F+2)'(r_bc);
        r_csec <= r_bsec;
    end

    // ---------------- stage D: place components and scale to 8 bits ----------------
    logic [F:0]   cr, cg, cb;
    logic [VW-1:0] vr, vg, vb;
    logic         r_ov;
    logic [31:0]  r_pixel;

    always_comb begin
        cr = '0;
        cg = '0;
        cb = '0;
        case (r_csec)
            ahsl_pkg::SEC_RG: begin cr = r_cc; cg = r_cx; end
            ahsl_pkg::SEC_GR: begin cr = r_cx; cg = r_cc; end
            ahsl_pkg::SEC_GB: begin cg = r_cc; cb = r_cx; end
            ahsl_pkg::SEC_BG: begin cg = r_cx; cb = r_cc; end
            ahsl_pkg::SEC_BR: begin cr = r_cx; cb = r_cc; end
            default:  begin cr = r_cc; cb = r_cx; end
        endcase
        vr = VW'(r_cm) + (VW'(cr) << 1);
        vg = VW'(r_cm) + (VW'(cg) << 1);
        vb = VW'(r_cm) + (VW'(cb) << 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_cv;
        end
        r_pixel <= {r_ca, to_chan(vr), to_chan(vg), to_chan(vb)};
    end

    assign o_strobe = r_ov;
    assign o_pixel  = r_pixel;

endmodule

/* src/argb_hsl_adjust.sv */
// ARGB hue / saturation / lightness adjuster.
//
// Requests: drive i_pixel_in and raise start; the pixel is taken at a rising
// edge where start is high and busy is low. One pixel may be taken every
// clock. Each pixel gives exactly one result on o_pixel_out, marked by
// o_strobe for one cycle; results come out in request order.
//
// Each pixel passes the front register, the classify queue and the restoring
// divider, which resolves one quotient bit per stage for hue and saturation
// in parallel lanes; lightness is a reciprocal multiply carried alongside.
// Throughput is one pixel per clock while busy is low.
// A front stage classifies each pixel into a small queue; the back pipeline
// drains that queue every cycle, so busy stays low in operation.
//
// Settings are written through i_cfg_we / i_cfg_idx / i_cfg_data while no
// request is in flight: 0 hue offset, 1 saturation offset, 2 lightness
// offset. Reset clears all offsets to zero and drops requests in flight.
// The receiver cannot stall: each result is shown for one cycle only.
module argb_hsl_adjust #(
    parameter int FRAC_BITS = ahsl_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [31:0]                     i_pixel_in,
    output logic                            o_strobe,
    output logic [31:0]                     o_pixel_out,
    input  logic                            i_cfg_we,
    input  logic [ahsl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ahsl_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int LAT = FRAC_BITS + 7;

    ahsl_pkg::t_cfg  r_cfg;
    ahsl_pkg::t_item front_item, q_item;
    logic            front_valid, q_empty, q_full, req;

    assign busy = q_full;
    assign req  = start && !busy;

    // Write settings
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ahsl_pkg::CFG_HUE: r_cfg.hue_ofs <= i_cfg_data[11:0];
                ahsl_pkg::CFG_SAT: r_cfg.sat_ofs <= $signed(i_cfg_data);
                ahsl_pkg::CFG_LIT: r_cfg.lit_ofs <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    ahsl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .i_pixel (i_pixel_in),
        .o_valid (front_valid),
        .o_item  (front_item)
    );

    ahsl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_item  (front_item),
        .i_pop   (!q_empty),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_item  (q_item)
    );

    ahsl_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!q_empty),
        .i_item   (q_item),
        .i_cfg    (r_cfg),
        .o_strobe (o_strobe),
        .o_pixel  (o_pixel_out)
    );

    // Back end drains the queue every cycle, so it never fills
    a_no_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !q_full)
        else $error("classify queue filled");

    // Every result traces back to a request a fixed time earlier
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LAT))
        else $error("result without matching request");

    // Every request gives a result after the fixed latency
    a_req_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_strobe)
        else $error("request lost");

    // Alpha rides along unchanged
    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_pixel_out[31:24] == $past(i_pixel_in[31:24], LAT)))
        else $error("alpha corrupted");

endmodule
